@@ hdl/kbt_pkg.sv @@
package kbt_pkg;

  localparam logic [1:0] ACT_ADVANCE = 2'd0;
  localparam logic [1:0] ACT_ACC     = 2'd1;
  localparam logic [1:0] ACT_GYR     = 2'd2;

  localparam logic [1:0] REG_ACC_WALK = 2'd0;
  localparam logic [1:0] REG_GYR_WALK = 2'd1;
  localparam logic [1:0] REG_ACC_INIT = 2'd2;
  localparam logic [1:0] REG_GYR_INIT = 2'd3;

  localparam int unsigned NUM_AXES = 3;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        dt;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
    logic [31:0]        meas_noise_x;
    logic [31:0]        meas_noise_y;
    logic [31:0]        meas_noise_z;
  } in_t;

  typedef struct packed {
    logic               sensor;
    logic signed [31:0] bias_x;
    logic signed [31:0] bias_y;
    logic signed [31:0] bias_z;
    logic [31:0]        var_x;
    logic [31:0]        var_y;
    logic [31:0]        var_z;
  } out_t;

  // commands from the controller to every lane
  typedef struct packed {
    logic        start;
    logic        sel;
    logic        advance;
    logic [31:0] inc_acc;
    logic [31:0] inc_gyr;
    logic        load_acc;
    logic        load_gyr;
    logic [31:0] load_val;
  } lane_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] bias;
    logic [31:0]        var_val;
  } lane_res_t;

  typedef struct packed {
    logic        done;
    logic [31:0] inc_acc;
    logic [31:0] inc_gyr;
  } grow_res_t;

endpackage

@@ hdl/imu_bias_kalman_tracker.sv @@
// Per-axis bias tracker for an accelerometer and a gyroscope: three lanes, one per axis, each
// hold both sensors' bias and variance and run a scalar Kalman update with a restoring divider
// for the 31-bit gain followed by two multiplies; the lanes run together and their results are
// merged into one output register. A measurement item is not followed by the next item until
// its result has been loaded into the output register. An advance item holds off the next item
// while the shared 32x32 multiplier forms dt^2 and the four walk partial products; an unused
// action is dropped. A result waiting in the output register does not hold up the next item's
// work, but an update that finishes while that result still waits is held until it is taken.
// Writing an init variance register also reloads that sensor's three variances.
module imu_bias_kalman_tracker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kbt_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kbt_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ADV   = 4'b0010,
    ST_UPD   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic                sel_r;
  logic [31:0]         acc_walk_r, gyr_walk_r;
  logic                out_valid_r;
  kbt_pkg::out_t       out_r;
  logic                in_xfer;
  logic                out_load;
  kbt_pkg::lane_cmd_t  cmd;
  kbt_pkg::lane_res_t  lane_res [kbt_pkg::NUM_AXES];
  logic signed [31:0]  lane_meas [kbt_pkg::NUM_AXES];
  logic [31:0]         lane_noise [kbt_pkg::NUM_AXES];
  kbt_pkg::grow_res_t  grow;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);

  assign lane_meas[0]  = in_data.meas_x;
  assign lane_meas[1]  = in_data.meas_y;
  assign lane_meas[2]  = in_data.meas_z;
  assign lane_noise[0] = in_data.meas_noise_x;
  assign lane_noise[1] = in_data.meas_noise_y;
  assign lane_noise[2] = in_data.meas_noise_z;

  always_comb begin
    cmd.start    = in_xfer && (in_data.action == kbt_pkg::ACT_ACC ||
                               in_data.action == kbt_pkg::ACT_GYR);
    cmd.sel      = (in_data.action == kbt_pkg::ACT_GYR);
    cmd.advance  = (state_r == ST_ADV) && grow.done;
    cmd.inc_acc  = grow.inc_acc;
    cmd.inc_gyr  = grow.inc_gyr;
    cmd.load_acc = cfg_we && (cfg_index == kbt_pkg::REG_ACC_INIT);
    cmd.load_gyr = cfg_we && (cfg_index == kbt_pkg::REG_GYR_INIT);
    cmd.load_val = cfg_wdata;
  end

  kbt_growth #(
    .FRAC_BITS (FRAC_BITS)
  ) u_growth (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer && in_data.action == kbt_pkg::ACT_ADVANCE),
    .dt       (in_data.dt),
    .acc_walk (acc_walk_r),
    .gyr_walk (gyr_walk_r),
    .res      (grow)
  );

  for (genvar i = 0; i < kbt_pkg::NUM_AXES; i++) begin : g_lane
    kbt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .meas  (lane_meas[i]),
      .noise (lane_noise[i]),
      .res   (lane_res[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.action)
            kbt_pkg::ACT_ADVANCE: state_nxt = ST_ADV;
            kbt_pkg::ACT_ACC:     state_nxt = ST_UPD;
            kbt_pkg::ACT_GYR:     state_nxt = ST_UPD;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADV:   if (grow.done) state_nxt = ST_IDLE;
      // lanes run in lock step, so lane 0 stands for all
      ST_UPD:   if (lane_res[0].done) state_nxt = ST_DRAIN;
      ST_DRAIN: if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= 1'b0;
      acc_walk_r  <= '0;
      gyr_walk_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.start) sel_r <= cmd.sel;
      if (cfg_we && cfg_index == kbt_pkg::REG_ACC_WALK) acc_walk_r <= cfg_wdata;
      if (cfg_we && cfg_index == kbt_pkg::REG_GYR_WALK) gyr_walk_r <= cfg_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // merge the three lanes into one result
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.sensor <= sel_r;
      out_r.bias_x <= lane_res[0].bias;
      out_r.bias_y <= lane_res[1].bias;
      out_r.bias_z <= lane_res[2].bias;
      out_r.var_x  <= lane_res[0].var_val;
      out_r.var_y  <= lane_res[1].var_val;
      out_r.var_z  <= lane_res[2].var_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/kbt_growth.sv @@
module kbt_growth #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       dt,
  input  logic [31:0]       acc_walk,
  input  logic [31:0]       gyr_walk,
  output kbt_pkg::grow_res_t res
);

  localparam int unsigned SH = 2 * FRAC_BITS;

  typedef enum logic [5:0] {
    G_IDLE = 6'b000001,
    G_ALO  = 6'b000010,
    G_AHI  = 6'b000100,
    G_GLO  = 6'b001000,
    G_GHI  = 6'b010000,
    G_GCMB = 6'b100000
  } gstate_t;

  gstate_t     state_r, state_nxt;
  logic        done_r;
  logic [63:0] mul_r;
  logic [63:0] d2_r;
  logic [63:0] lo_r;
  logic [31:0] inc_acc_r;
  logic [31:0] inc_gyr_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  // walk * dt^2 from its two partial products, scaled down and saturated
  function automatic logic [31:0] combine(input logic [63:0] lo, input logic [63:0] hi);
    logic [64:0] upper;
    logic [96:0] full;
    logic [96:0] over;
    upper = {1'b0, hi} + {33'b0, lo[63:32]};
    full  = {upper, lo[31:0]};
    over  = full >> (SH + 32);
    if (over != '0) begin
      combine = '1;
    end else begin
      combine = full[SH +: 32];
    end
  endfunction

  always_comb begin
    op_a = dt;
    op_b = dt;
    case (state_r)
      G_ALO: begin
        op_a = acc_walk;
        op_b = mul_r[31:0];
      end
      G_AHI: begin
        op_a = acc_walk;
        op_b = d2_r[63:32];
      end
      G_GLO: begin
        op_a = gyr_walk;
        op_b = d2_r[31:0];
      end
      G_GHI: begin
        op_a = gyr_walk;
        op_b = d2_r[63:32];
      end
      default: begin
        op_a = dt;
        op_b = dt;
      end
    endcase
  end

  assign prod = 64'(op_a) * 64'(op_b);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      G_IDLE: if (start) state_nxt = G_ALO;
      G_ALO:  state_nxt = G_AHI;
      G_AHI:  state_nxt = G_GLO;
      G_GLO:  state_nxt = G_GHI;
      G_GHI:  state_nxt = G_GCMB;
      G_GCMB: state_nxt = G_IDLE;
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == G_GCMB);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      G_IDLE: if (start) mul_r <= prod;
      G_ALO: begin
        d2_r  <= mul_r;
        mul_r <= prod;
      end
      G_AHI: begin
        lo_r  <= mul_r;
        mul_r <= prod;
      end
      G_GLO: begin
        inc_acc_r <= combine(lo_r, mul_r);
        mul_r     <= prod;
      end
      G_GHI: begin
        lo_r  <= mul_r;
        mul_r <= prod;
      end
      G_GCMB: inc_gyr_r <= combine(lo_r, mul_r);
      default: mul_r <= mul_r;
    endcase
  end

  assign res.done    = done_r;
  assign res.inc_acc = inc_acc_r;
  assign res.inc_gyr = inc_gyr_r;

endmodule

@@ hdl/kbt_lane.sv @@
module kbt_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  kbt_pkg::lane_cmd_t cmd,
  input  logic signed [31:0] meas,
  input  logic [31:0]        noise,
  output kbt_pkg::lane_res_t res
);

  localparam logic [31:0] RST_VAR = 32'd1 << FRAC_BITS;
  localparam int unsigned QBITS   = 31;
  localparam logic [4:0]  QLAST   = 5'(QBITS - 1);

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_DIV  = 5'b00010,
    L_MULA = 5'b00100,
    L_MULB = 5'b01000,
    L_WB   = 5'b10000
  } lstate_t;

  lstate_t            state_r, state_nxt;
  logic               sel_r;
  logic [4:0]         cnt_r;
  logic signed [31:0] acc_x_r, gyr_x_r;
  logic [31:0]        acc_p_r, gyr_p_r;

  logic [33:0]        s_r;
  logic [33:0]        rem_r;
  logic [QBITS-1:0]   q_r;
  logic [32:0]        mag_r;
  logic               neg_r;
  logic [31:0]        p_r;
  logic signed [31:0] x_r;
  logic [63:0]        prod_r;
  logic [32:0]        step_r;

  logic [31:0]        p_sel;
  logic signed [31:0] x_sel;
  logic [32:0]        y;
  logic [34:0]        rem2;
  logic [35:0]        diff;
  logic               q_bit;
  logic [32:0]        mul_b;
  logic [63:0]        prod;
  logic [31:0]        p_new;
  logic signed [34:0] x_sum;
  logic signed [31:0] x_new;
  logic [32:0]        acc_grow, gyr_grow;

  assign p_sel = cmd.sel ? gyr_p_r : acc_p_r;
  assign x_sel = cmd.sel ? gyr_x_r : acc_x_r;
  assign y     = {meas[31], meas} - {x_sel[31], x_sel};

  // restoring division, one quotient bit a cycle
  assign rem2  = {rem_r, 1'b0};
  assign diff  = {1'b0, rem2} - {2'b0, s_r};
  assign q_bit = ~diff[35];

  assign mul_b = (state_r == L_MULA) ? mag_r : {1'b0, p_r};
  assign prod  = 64'(q_r) * 64'(mul_b);

  assign p_new = p_r - prod_r[62:31];
  assign x_sum = neg_r ? (35'(x_r) - $signed({2'b0, step_r}))
                       : (35'(x_r) + $signed({2'b0, step_r}));

  always_comb begin
    if (x_sum[34:31] == 4'b0000 || x_sum[34:31] == 4'b1111) begin
      x_new = x_sum[31:0];
    end else if (x_sum[34]) begin
      x_new = {1'b1, 31'b0};
    end else begin
      x_new = {1'b0, {31{1'b1}}};
    end
  end

  assign acc_grow = {1'b0, acc_p_r} + {1'b0, cmd.inc_acc};
  assign gyr_grow = {1'b0, gyr_p_r} + {1'b0, cmd.inc_gyr};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE: if (cmd.start) state_nxt = L_DIV;
      L_DIV:  if (cnt_r == QLAST) state_nxt = L_MULA;
      L_MULA: state_nxt = L_MULB;
      L_MULB: state_nxt = L_WB;
      L_WB:   state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      sel_r   <= 1'b0;
      cnt_r   <= '0;
      acc_x_r <= '0;
      gyr_x_r <= '0;
      acc_p_r <= RST_VAR;
      gyr_p_r <= RST_VAR;
    end else begin
      state_r <= state_nxt;
      if (state_r == L_IDLE && cmd.start) begin
        sel_r <= cmd.sel;
        cnt_r <= '0;
      end else if (state_r == L_DIV) begin
        cnt_r <= cnt_r + 5'd1;
      end
      if (cmd.advance) begin
        acc_p_r <= acc_grow[32] ? '1 : acc_grow[31:0];
        gyr_p_r <= gyr_grow[32] ? '1 : gyr_grow[31:0];
      end
      if (cmd.load_acc) acc_p_r <= cmd.load_val;
      if (cmd.load_gyr) gyr_p_r <= cmd.load_val;
      if (state_r == L_WB) begin
        if (sel_r) begin
          gyr_x_r <= x_new;
          gyr_p_r <= p_new;
        end else begin
          acc_x_r <= x_new;
          acc_p_r <= p_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          s_r   <= {2'b0, p_sel} + {2'b0, noise} + 34'd1;
          rem_r <= {2'b0, p_sel};
          q_r   <= '0;
          p_r   <= p_sel;
          x_r   <= x_sel;
          neg_r <= y[32];
          mag_r <= y[32] ? (~y + 33'd1) : y;
        end
      end
      L_DIV: begin
        rem_r <= q_bit ? diff[33:0] : rem2[33:0];
        q_r   <= {q_r[QBITS-2:0], q_bit};
      end
      L_MULA: prod_r <= prod;
      L_MULB: begin
        step_r <= prod_r[63:31];
        prod_r <= prod;
      end
      default: prod_r <= prod_r;
    endcase
  end

  assign res.done    = (state_r == L_WB);
  assign res.bias    = sel_r ? gyr_x_r : acc_x_r;
  assign res.var_val = sel_r ? gyr_p_r : acc_p_r;

endmodule

@@ test/bias_track_checker.sv @@
`timescale 1ns / 1ps

module bias_track_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  kbt_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  kbt_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  output int            fail_count,
  output int            outstanding
);

  localparam int unsigned FRAC = 16;
  localparam int SNS_ACC = 0;
  localparam int SNS_GYR = 1;
  localparam logic [31:0] UNITY_VAR = 32'h0001_0000;
  localparam longint BIAS_MAX = 64'sd2147483647;
  localparam longint BIAS_MIN = -64'sd2147483648;

  logic [31:0]   walk_rate [2];
  longint        bias_est  [2][kbt_pkg::NUM_AXES];
  logic [31:0]   bias_var  [2][kbt_pkg::NUM_AXES];
  kbt_pkg::out_t reports_due [$];
  int            errors = 0;

  // walk * dt^2 scaled back to the value format, clipped to 32 bits
  function automatic logic [31:0] walk_growth(logic [31:0] walk, logic [31:0] dt);
    logic [95:0] prod;
    prod = 96'(walk) * 96'(dt) * 96'(dt);
    prod = prod >> (2 * FRAC);
    return (prod > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  // one scalar Kalman correction on a single axis of one sensor
  task automatic correct_axis(input int sns, input int axis, input logic signed [31:0] z,
                              input logic [31:0] r);
    logic [63:0] s_sum;
    logic [63:0] gain;
    logic [63:0] mag;
    logic [63:0] step;
    logic [31:0] p;
    longint      resid;
    longint      nx;
    p     = bias_var[sns][axis];
    s_sum = 64'(p) + 64'(r) + 64'd1;
    gain  = (64'(p) << 31) / s_sum;
    resid = longint'(z) - bias_est[sns][axis];
    mag   = (resid < 0) ? 64'(-resid) : 64'(resid);
    step  = (gain * mag) >> 31;
    nx    = (resid < 0) ? bias_est[sns][axis] - longint'(step)
                        : bias_est[sns][axis] + longint'(step);
    if (nx > BIAS_MAX) nx = BIAS_MAX;
    if (nx < BIAS_MIN) nx = BIAS_MIN;
    bias_est[sns][axis] = nx;
    bias_var[sns][axis] = p - 32'((gain * 64'(p)) >> 31);
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    kbt_pkg::out_t want;
    logic [31:0]   inc;
    logic [32:0]   sum;
    int            sns;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        walk_rate[s] = '0;
        for (int i = 0; i < kbt_pkg::NUM_AXES; i++) begin
          bias_est[s][i] = 0;
          bias_var[s][i] = UNITY_VAR;
        end
      end
      reports_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with none expected: %h", $realtime, out_data);
        end else begin
          want = reports_due.pop_front();
          compare_field("sensor", 32'(want.sensor), 32'(out_data.sensor));
          compare_field("bias_x", want.bias_x, out_data.bias_x);
          compare_field("bias_y", want.bias_y, out_data.bias_y);
          compare_field("bias_z", want.bias_z, out_data.bias_z);
          compare_field("var_x", want.var_x, out_data.var_x);
          compare_field("var_y", want.var_y, out_data.var_y);
          compare_field("var_z", want.var_z, out_data.var_z);
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          kbt_pkg::REG_ACC_WALK: walk_rate[SNS_ACC] = cfg_wdata;
          kbt_pkg::REG_GYR_WALK: walk_rate[SNS_GYR] = cfg_wdata;
          kbt_pkg::REG_ACC_INIT:
            for (int i = 0; i < kbt_pkg::NUM_AXES; i++) bias_var[SNS_ACC][i] = cfg_wdata;
          kbt_pkg::REG_GYR_INIT:
            for (int i = 0; i < kbt_pkg::NUM_AXES; i++) bias_var[SNS_GYR][i] = cfg_wdata;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        case (in_data.action)
          kbt_pkg::ACT_ADVANCE: begin
            for (int s = 0; s < 2; s++) begin
              inc = walk_growth(walk_rate[s], in_data.dt);
              for (int i = 0; i < kbt_pkg::NUM_AXES; i++) begin
                sum = 33'(bias_var[s][i]) + 33'(inc);
                bias_var[s][i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              end
            end
          end
          kbt_pkg::ACT_ACC, kbt_pkg::ACT_GYR: begin
            sns = (in_data.action == kbt_pkg::ACT_ACC) ? SNS_ACC : SNS_GYR;
            correct_axis(sns, 0, in_data.meas_x, in_data.meas_noise_x);
            correct_axis(sns, 1, in_data.meas_y, in_data.meas_noise_y);
            correct_axis(sns, 2, in_data.meas_z, in_data.meas_noise_z);
            want.sensor = 1'(sns);
            want.bias_x = 32'(bias_est[sns][0]);
            want.bias_y = 32'(bias_est[sns][1]);
            want.bias_z = 32'(bias_est[sns][2]);
            want.var_x  = bias_var[sns][0];
            want.var_y  = bias_var[sns][1];
            want.var_z  = bias_var[sns][2];
            reports_due = {reports_due, want};
          end
          default: ;
        endcase
      end
    end
    fail_count  <= errors;
    outstanding <= reports_due.size();
  end

endmodule

@@ test/tb_imu_bias_kalman_tracker.sv @@
`timescale 1ns / 1ps

module tb_imu_bias_kalman_tracker;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 48;
  localparam int PHASE_ITEMS  = 280;
  localparam int NUM_PHASES   = 6;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN   = 32'h8000_0000;
  localparam logic [31:0] UNITY_VAR = 32'h0001_0000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  kbt_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  kbt_pkg::out_t out_data;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [31:0]   cfg_wdata;
  int            fail_count;
  int            outstanding;
  int            idle_cycles = 0;
  logic          steady = 1'b0;

  imu_bias_kalman_tracker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bias_track_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 38);

  // no transfer of any kind for too long means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic kbt_pkg::in_t sample(logic [1:0] act, logic [31:0] dt,
                                          logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                                          logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
    kbt_pkg::in_t s;
    s.action       = act;
    s.dt           = dt;
    s.meas_x       = mx;
    s.meas_y       = my;
    s.meas_z       = mz;
    s.meas_noise_x = rx;
    s.meas_noise_y = ry;
    s.meas_noise_z = rz;
    return s;
  endfunction

  // mostly modest values, with extremes and full-range words mixed in
  function automatic logic [31:0] pick_word(logic [31:0] span, bit centred);
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 6) return 32'h0;
    if (sel < 12) return ALL_ONES;
    if (sel < 15) return NEG_MIN;
    if (sel < 18) return POS_MAX;
    if (sel < 35) return $urandom;
    v = $urandom_range(span);
    return centred ? v - (span >> 1) : v;
  endfunction

  function automatic kbt_pkg::in_t random_sample();
    int unsigned sel;
    logic [1:0]  act;
    sel = $urandom_range(99);
    if (sel < 6) act = ACT_UNUSED;
    else if (sel < 36) act = kbt_pkg::ACT_ADVANCE;
    else if (sel < 68) act = kbt_pkg::ACT_ACC;
    else act = kbt_pkg::ACT_GYR;
    return sample(act, pick_word(32'h0002_0000, 1'b0),
                  pick_word(32'h0020_0000, 1'b1), pick_word(32'h0020_0000, 1'b1),
                  pick_word(32'h0020_0000, 1'b1), pick_word(32'h0004_0000, 1'b0),
                  pick_word(32'h0004_0000, 1'b0), pick_word(32'h0004_0000, 1'b0));
  endfunction

  task automatic push_sample(input kbt_pkg::in_t item);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off until every report is back, then let trailing advances finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] aw, input logic [31:0] gw,
                           input logic [31:0] ai, input logic [31:0] gi);
    write_reg(kbt_pkg::REG_ACC_WALK, aw);
    write_reg(kbt_pkg::REG_GYR_WALK, gw);
    write_reg(kbt_pkg::REG_ACC_INIT, ai);
    write_reg(kbt_pkg::REG_GYR_INIT, gi);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = kbt_pkg::REG_ACC_WALK;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero walk, unit variance
    push_sample(sample(kbt_pkg::ACT_ACC, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    push_sample(sample(kbt_pkg::ACT_ACC, 32'h0, POS_MAX, NEG_MIN, 32'h1,
                       ALL_ONES, 32'h0, UNITY_VAR));
    push_sample(sample(kbt_pkg::ACT_GYR, ALL_ONES, NEG_MIN, POS_MAX, ALL_ONES,
                       32'h0, ALL_ONES, 32'h1));
    push_sample(sample(ACT_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                       ALL_ONES, ALL_ONES, ALL_ONES));
    push_sample(sample(kbt_pkg::ACT_ADVANCE, ALL_ONES, 32'h0, 32'h0, 32'h0,
                       32'h0, 32'h0, 32'h0));
    push_sample(sample(kbt_pkg::ACT_GYR, 32'h0, 32'h0001_8000, 32'hFFFF_4000, 32'h0000_0100,
                       32'h0000_1000, UNITY_VAR, 32'h0000_0010));
    settle();

    // extreme settings: saturating growth, full and empty initial variance
    write_all(ALL_ONES, 32'h1, ALL_ONES, 32'h0);
    push_sample(sample(kbt_pkg::ACT_GYR, 32'h0, POS_MAX, NEG_MIN, 32'h1234_5678,
                       32'h0, 32'h0, 32'h0));
    push_sample(sample(kbt_pkg::ACT_ACC, 32'h0, NEG_MIN, POS_MAX, 32'h0,
                       32'h0, 32'h0, 32'h0));
    push_sample(sample(kbt_pkg::ACT_ADVANCE, ALL_ONES, 32'h0, 32'h0, 32'h0,
                       32'h0, 32'h0, 32'h0));
    push_sample(sample(kbt_pkg::ACT_ACC, 32'h0, POS_MAX, NEG_MIN, 32'h0,
                       ALL_ONES, ALL_ONES, ALL_ONES));
    push_sample(sample(kbt_pkg::ACT_ADVANCE, 32'h1, 32'h0, 32'h0, 32'h0,
                       32'h0, 32'h0, 32'h0));
    push_sample(sample(kbt_pkg::ACT_GYR, 32'h0, ALL_ONES, 32'h1, NEG_MIN,
                       32'h1, 32'h0, ALL_ONES));
    push_sample(sample(kbt_pkg::ACT_ADVANCE, 32'h0, ALL_ONES, ALL_ONES, ALL_ONES,
                       ALL_ONES, ALL_ONES, ALL_ONES));
    push_sample(sample(ACT_UNUSED, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    push_sample(sample(kbt_pkg::ACT_ACC, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    push_sample(sample(kbt_pkg::ACT_GYR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_all(32'h0000_0400, 32'h0000_0040, UNITY_VAR, 32'h0000_8000);
        1: write_all($urandom_range(32'h0002_0000), $urandom_range(32'h0002_0000),
                     $urandom_range(32'h0010_0000), $urandom_range(32'h0010_0000));
        2: write_all(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        3: write_all(32'h0, 32'h0, 32'h1, ALL_ONES);
        default: write_all(pick_word(32'h0002_0000, 1'b0), pick_word(32'h0002_0000, 1'b0),
                           pick_word(32'h0010_0000, 1'b0), pick_word(32'h0010_0000, 1'b0));
      endcase
      // one whole phase runs with neither side idling
      steady = (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (outstanding != 0) @(posedge clk);
        end
        push_sample(random_sample());
      end
      settle();
    end
    steady = 1'b0;

    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
